// ===== src/hpe_pkg.sv =====
// Package for the Horner polynomial evaluator: widths, register indexes,
// Q16.16 limits and the control struct passed between pipeline steps.
// No dependencies.
package hpe_pkg;

  localparam int unsigned QW            = 32;  // Q16.16 word
  localparam int unsigned FracW         = 16;
  localparam int unsigned ProdW         = 2 * QW;
  localparam int unsigned NumCoefs      = 7;
  localparam int unsigned DegW          = 3;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned MaxDegreeDflt = 6;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegDegree = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoef0  = 3'd1;

  localparam logic signed [QW-1:0]    QMax  = 32'sh7fff_ffff;
  localparam logic signed [QW-1:0]    QMin  = -32'sh7fff_ffff - 32'sd1;
  localparam logic signed [ProdW-1:0] RndHalf = 64'sd32768;

  typedef struct packed {
    logic valid;
    logic ovf;
  } hpe_ctl_t;

endpackage

// ===== src/horner_polynomial_evaluator.sv =====
// Top level of the Horner polynomial evaluator: configuration registers,
// entry stage and a chain of hpe_step instances. Depends on hpe_pkg, hpe_step.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------
//  config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//  sample   | in_valid_i / in_stall_o    | sample_x_i
//  result   | out_valid_o / out_stall_i  | poly_value_o, overflow_o
//
// One word per cycle in and out while the result side does not stall; the path
// runs through one entry register and a multiply stage plus a round/add stage per step.
// A stalled result freezes the whole pipeline; in_stall_o follows at once.
// Reset clears the degree, all coefficients and all valid bits.
// Lower degrees run with a zero accumulator through the unused steps.
module horner_polynomial_evaluator #(
  parameter int unsigned MAX_DEGREE = hpe_pkg::MaxDegreeDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hpe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hpe_pkg::QW-1:0]            cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [hpe_pkg::QW-1:0]     sample_x_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hpe_pkg::QW-1:0]     poly_value_o,
  output logic                              overflow_o
);
  import hpe_pkg::*;

  localparam logic [DegW-1:0] MaxDeg = DegW'(MAX_DEGREE);

  logic [DegW-1:0]       degree_q;
  logic signed [QW-1:0]  coef_q [NumCoefs];
  logic [DegW-1:0]       deg_eff;
  logic                  en;

  hpe_ctl_t              ctl_s [MAX_DEGREE+1];
  logic signed [QW-1:0]  acc_s [MAX_DEGREE+1];
  logic signed [QW-1:0]  x_s   [MAX_DEGREE+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      for (int i = 0; i < NumCoefs; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegDegree) begin
        degree_q <= cfg_data_i[DegW-1:0];
      end else begin
        coef_q[cfg_idx_i - RegCoef0] <= cfg_data_i;
      end
    end
  end

  assign deg_eff = (degree_q > MaxDeg) ? MaxDeg : degree_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // entry stage: accumulator starts at the top coefficient only at full degree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s[0] <= '0;
    end else if (en) begin
      ctl_s[0] <= '{valid: in_valid_i, ovf: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_s[0] <= (deg_eff == MaxDeg) ? coef_q[MAX_DEGREE] : '0;
      x_s[0]   <= sample_x_i;
    end
  end

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
    localparam int unsigned CIdx = MAX_DEGREE - 1 - k;
    logic signed [QW-1:0] addend;

    // coefficients above the degree add nothing
    assign addend = (DegW'(CIdx) <= deg_eff) ? coef_q[CIdx] : '0;

    hpe_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_s[k]),
      .acc_i  (acc_s[k]),
      .x_i    (x_s[k]),
      .coef_i (addend),
      .ctl_o  (ctl_s[k+1]),
      .acc_o  (acc_s[k+1]),
      .x_o    (x_s[k+1])
    );
  end

  assign out_valid_o  = ctl_s[MAX_DEGREE].valid;
  assign overflow_o   = ctl_s[MAX_DEGREE].ovf;
  assign poly_value_o = acc_s[MAX_DEGREE];

  // constant polynomial: value is coef_0 with no saturation
  a_deg0_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && deg_eff == '0) |-> (poly_value_o == coef_q[0]))
    else $error("degree zero result differs from constant term");

  a_deg0_noovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && deg_eff == '0) |-> !overflow_o)
    else $error("overflow flagged at degree zero");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

endmodule

// ===== src/hpe_step.sv =====
// One Horner step in two register stages: multiply, then round, saturate,
// add coefficient and saturate again. Depends on hpe_pkg.
module hpe_step (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  hpe_pkg::hpe_ctl_t                ctl_i,
  input  logic signed [hpe_pkg::QW-1:0]    acc_i,
  input  logic signed [hpe_pkg::QW-1:0]    x_i,
  input  logic signed [hpe_pkg::QW-1:0]    coef_i,
  output hpe_pkg::hpe_ctl_t                ctl_o,
  output logic signed [hpe_pkg::QW-1:0]    acc_o,
  output logic signed [hpe_pkg::QW-1:0]    x_o
);
  import hpe_pkg::*;

  localparam int unsigned RndW = ProdW - FracW;

  // multiply stage
  hpe_ctl_t                ctl_m_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [QW-1:0]    x_m_q;

  // round / add stage
  hpe_ctl_t                ctl_q;
  logic signed [QW-1:0]    acc_q;
  logic signed [QW-1:0]    x_q;

  logic signed [ProdW-1:0] rnd;
  logic signed [RndW-1:0]  rnd_sh;
  logic                    prod_ovf;
  logic signed [QW-1:0]    prod_sat;
  logic signed [QW:0]      sum;
  logic                    sum_ovf;
  logic signed [QW-1:0]    acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_m_q <= '0;
      ctl_q   <= '0;
    end else if (en_i) begin
      ctl_m_q <= ctl_i;
      ctl_q   <= '{valid: ctl_m_q.valid, ovf: ctl_m_q.ovf | prod_ovf | sum_ovf};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(acc_i) * ProdW'(x_i);
      x_m_q  <= x_i;
      acc_q  <= acc_d;
      x_q    <= x_m_q;
    end
  end

  // round to nearest, ties up: add half an LSB, floor shift
  always_comb begin
    rnd      = prod_q + RndHalf;
    rnd_sh   = rnd[ProdW-1:FracW];
    prod_ovf = !((&rnd_sh[RndW-1:QW-1]) || !(|rnd_sh[RndW-1:QW-1]));
    if (prod_ovf) begin
      prod_sat = rnd_sh[RndW-1] ? QMin : QMax;
    end else begin
      prod_sat = rnd_sh[QW-1:0];
    end
    sum     = {prod_sat[QW-1], prod_sat} + {coef_i[QW-1], coef_i};
    sum_ovf = sum[QW] ^ sum[QW-1];
    if (sum_ovf) begin
      acc_d = sum[QW] ? QMin : QMax;
    end else begin
      acc_d = sum[QW-1:0];
    end
  end

  assign ctl_o = ctl_q;
  assign acc_o = acc_q;
  assign x_o   = x_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for horner_polynomial_evaluator: drives samples and
// register settings, predicts each Q16.16 result and checks it field by field.
// Depends on hpe_pkg and the horner_polynomial_evaluator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpe_pkg::*;

  localparam int unsigned Latency    = 1 + 2 * MaxDegreeDflt;
  localparam int unsigned HoldLen    = 160;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned IdlePct    = 22;

  typedef struct packed {
    logic signed [QW-1:0] value;
    logic                 ovf;
  } poly_res_t;

  typedef enum int {MagSmall, MagMid, MagFull, MagCorner} mag_e;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i    = '0;
  logic [QW-1:0]        cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic signed [QW-1:0] sample_x_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic signed [QW-1:0] poly_value_o;
  logic                 overflow_o;

  // predictor copy of the registers
  logic [DegW-1:0]      deg_q = '0;
  logic signed [QW-1:0] coef_q [NumCoefs];

  poly_res_t   pending_values[$];
  poly_res_t   head_r;
  int unsigned mismatches  = 0;
  int unsigned idle_pct    = IdlePct;
  int unsigned stall_pct   = IdlePct;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned quiet_count = 0;

  horner_polynomial_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_x_i  (sample_x_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .poly_value_o(poly_value_o),
    .overflow_o  (overflow_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit q_over(longint v);
    return (v > longint'(QMax)) || (v < longint'(QMin));
  endfunction

  function automatic longint q_clamp(longint v);
    if (v > longint'(QMax)) return longint'(QMax);
    if (v < longint'(QMin)) return longint'(QMin);
    return v;
  endfunction

  // Horner evaluation: round product to nearest (ties up), saturate, add, saturate
  function automatic poly_res_t horner_eval(logic signed [QW-1:0] x);
    poly_res_t r;
    longint    acc;
    longint    q;
    int        d;
    bit        ovf;
    d   = (int'(deg_q) > int'(MaxDegreeDflt)) ? int'(MaxDegreeDflt) : int'(deg_q);
    ovf = 1'b0;
    acc = coef_q[d];
    for (int i = d - 1; i >= 0; i--) begin
      q = (acc * longint'(x) + 64'sd32768) >>> FracW;
      ovf |= q_over(q);
      q = q_clamp(q) + longint'(coef_q[i]);
      ovf |= q_over(q);
      acc = q_clamp(q);
    end
    r.value = acc[QW-1:0];
    r.ovf   = ovf;
    return r;
  endfunction

  function automatic logic signed [QW-1:0] rand_q(mag_e m);
    case (m)
      MagSmall: return QW'($urandom_range(0, 262144)) - 32'sd131072;
      MagMid:   return QW'($urandom_range(0, 33554432)) - 32'sd16777216;
      MagFull:  return $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0:       return QMax;
          1:       return QMin;
          2:       return 32'sh0001_0000;
          3:       return -32'sh0001_0000;
          4:       return 32'sd1;
          5:       return -32'sd1;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic mag_e pick_mag();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return MagSmall;
    if (p < 75) return MagMid;
    if (p < 92) return MagFull;
    return MagCorner;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_values.size() == 0) begin
        note_failure($sformatf("unexpected word value=%h ovf=%b", poly_value_o, overflow_o));
      end else begin
        head_r = pending_values.pop_front();
        if (poly_value_o !== head_r.value)
          note_failure($sformatf("poly_value exp=%h got=%h", head_r.value, poly_value_o));
        if (overflow_o !== head_r.ovf)
          note_failure($sformatf("overflow exp=%b got=%b (value %h)", head_r.ovf,
                                 overflow_o, head_r.value));
      end
    end
  end

  // watchdog: cycles with no word moving on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni)
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", quiet_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [QW-1:0] x);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    pending_values.push_back(horner_eval(x));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // writes every register from the predictor copy; deg_word may carry junk above bit 2
  task automatic program_regs(input logic [QW-1:0] deg_word);
    wait_drain();
    deg_q = deg_word[DegW-1:0];
    for (int r = 0; r <= int'(NumCoefs); r++) begin
      cfg_we_i <= 1'b1;
      if (r == 0) begin
        cfg_idx_i  <= RegDegree;
        cfg_data_i <= deg_word;
      end else begin
        cfg_idx_i  <= RegCoef0 + CfgIdxW'(r - 1);
        cfg_data_i <= coef_q[r-1];
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_sample(QMax);
    send_sample(QMin);
    send_sample('0);
  endtask

  task automatic test_degree_zero();
    coef_q[0] = QMin;
    for (int i = 1; i < int'(NumCoefs); i++) coef_q[i] = QMax;
    program_regs(32'hffff_fff8);
    send_sample(QMax);
    send_sample(QMin);
    send_sample(32'sh0001_0000);
  endtask

  // half-LSB products: ties go towards plus infinity
  task automatic test_rounding_ties();
    foreach (coef_q[i]) coef_q[i] = '0;
    coef_q[1] = 32'sd1;
    program_regs(32'd1);
    send_sample(32'sd32768);
    send_sample(-32'sd32768);
    coef_q[1] = -32'sd3;
    program_regs(32'd1);
    send_sample(32'sd32768);
    send_sample(-32'sd32768);
  endtask

  task automatic test_saturation();
    foreach (coef_q[i]) coef_q[i] = QMax;
    program_regs(32'd7);  // code above the maximum degree
    send_sample(QMax);
    send_sample(QMin);
    send_sample('0);
    send_sample(-32'sh0001_0000);
    foreach (coef_q[i]) coef_q[i] = (i % 2) ? QMin : QMax;
    program_regs(32'd6);
    send_sample(QMin);
    send_sample(32'sh0002_0000);
    send_sample(-32'sd1);
  endtask

  task automatic test_cubic();
    foreach (coef_q[i]) coef_q[i] = '0;
    coef_q[0] = 32'sh0001_0000;   //  1.0
    coef_q[1] = -32'sh0002_0000;  // -2.0
    coef_q[2] = 32'sh0000_8000;   //  0.5
    coef_q[3] = 32'sh0000_4000;   //  0.25
    program_regs(32'd3);
    send_sample(32'sh0002_0000);
    send_sample(-32'sh0003_8000);
    send_sample(32'sd41);
    send_sample(32'sh0100_0000);
  endtask

  // hold the result side off while samples keep coming, so the pipe fills
  task automatic test_backpressure();
    foreach (coef_q[i]) coef_q[i] = rand_q(MagSmall);
    program_regs(32'd6);
    idle_pct = 0;
    hold_req++;
    repeat (50) send_sample(rand_q(pick_mag()));
    idle_pct = IdlePct;
  endtask

  task automatic test_random_settings();
    mag_e        cmag;
    logic [2:0]  deg;
    int unsigned p;
    for (int s = 0; s < 12; s++) begin
      p    = $urandom_range(0, 99);
      cmag = (p < 50) ? MagSmall : (p < 70) ? MagMid : (p < 85) ? MagFull : MagCorner;
      foreach (coef_q[i]) coef_q[i] = ($urandom_range(0, 4) == 0) ? rand_q(pick_mag())
                                                                   : rand_q(cmag);
      deg = (s < 8) ? 3'(s) : 3'($urandom_range(0, 7));
      program_regs(($urandom & 32'hffff_fff8) | {29'd0, deg});
      if (s == 5) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      repeat (150) send_sample(rand_q(pick_mag()));
      idle_pct  = IdlePct;
      stall_pct = IdlePct;
    end
  endtask

  initial begin
    foreach (coef_q[i]) coef_q[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_degree_zero();
    test_rounding_ties();
    test_saturation();
    test_cubic();
    test_backpressure();
    test_random_settings();
    wait_drain();
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
